FILE: rtl/core/cfa_pkg.sv
// Shared types and constants of the contiguous fit allocator.
// No dependencies; cfa_if and the allocator import it.
`default_nettype none

package cfa_pkg;

    // Fixed field widths of the request, result and configuration channels
    localparam int ID_W    = 8;
    localparam int SIZE_W  = 8;
    localparam int START_W = 7;
    localparam int SWAP_W  = 4;
    localparam int AGE_W   = 16;
    localparam int CNT_W   = 6;
    localparam int USED_W  = 8;
    localparam int POL_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Fit policy codes
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_LIMIT = 1'd1;

    // Result kinds
    localparam logic EV_PLACE = 1'b0;
    localparam logic EV_EVICT = 1'b1;

    localparam logic [SWAP_W-1:0] SWAP_MAX = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_SHIFT,
        ST_INSERT
    } cfa_state_t;

    typedef struct packed {
        logic                event_kind;
        logic [ID_W-1:0]     out_id;
        logic [SIZE_W-1:0]   out_size;
        logic [START_W-1:0]  out_start;
        logic [SWAP_W-1:0]   out_swaps;
        logic                requeue;
        logic [CNT_W-1:0]    resident_count;
        logic [CNT_W-1:0]    hole_count;
        logic [USED_W-1:0]   used_units;
        logic                last;
    } res_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/cfa_if.sv
// Channel interfaces of the allocator: request, result and configuration write.
// Depends on cfa_pkg for field widths.
`default_nettype none

interface cfa_req_if;
    import cfa_pkg::*;
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   proc_id;
    logic [SIZE_W-1:0] req_size;
    logic [SWAP_W-1:0] swap_count;
    modport source (output valid, proc_id, req_size, swap_count, input ready);
    modport sink   (input valid, proc_id, req_size, swap_count, output ready);
endinterface

interface cfa_res_if;
    import cfa_pkg::*;
    logic               valid;
    logic               ready;
    logic               event_kind;
    logic [ID_W-1:0]    out_id;
    logic [SIZE_W-1:0]  out_size;
    logic [START_W-1:0] out_start;
    logic [SWAP_W-1:0]  out_swaps;
    logic               requeue;
    logic [CNT_W-1:0]   resident_count;
    logic [CNT_W-1:0]   hole_count;
    logic [USED_W-1:0]  used_units;
    logic               last;
    modport source (output valid, event_kind, out_id, out_size, out_start, out_swaps,
                    requeue, resident_count, hole_count, used_units, last, input ready);
    modport sink   (input valid, event_kind, out_id, out_size, out_start, out_swaps,
                    requeue, resident_count, hole_count, used_units, last, output ready);
endinterface

interface cfa_cfg_if;
    import cfa_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cfa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module cfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/contiguous_fit_allocator_with_eviction.sv
// Contiguous fit allocator with eviction of the oldest-loaded segment. Resident
// segments live in one RAM sorted by start address. Each request is handled one
// at a time: a scan over the table finds the hole by the configured policy, the
// oldest segment and the hole count. Either an insert or an eviction follows. An
// insert moves the entries above the hole up, one per cycle, then writes the new
// entry. An eviction moves the entries above the victim down in the same way. The
// table is then scanned again to settle the hole count of the result. The scans
// and the moves are paced by the RAM's single read port. Out-of-range sizes are
// dropped without a result. Depends on cfa_pkg, cfa_if and cfa_ram.
`default_nettype none

module contiguous_fit_allocator_with_eviction #(
    parameter int MEM_UNITS    = 128,
    parameter int MAX_SEGMENTS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cfa_req_if.sink   req,
    cfa_res_if.source res,
    cfa_cfg_if.sink   cfg
);
    import cfa_pkg::*;

    localparam int UW = $clog2(MEM_UNITS + 1);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int HW = $clog2(MAX_SEGMENTS + 2);
    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int EW = 2 * UW + ID_W + SWAP_W + AGE_W;

    localparam logic [UW-1:0] MEM_TOP = UW'(MEM_UNITS);
    localparam logic [CW-1:0] SEG_MAX = CW'(MAX_SEGMENTS);

    // State and control registers
    cfa_state_t        state_reg, state_next;
    logic [POL_W-1:0]  fit_policy_reg, fit_policy_next;
    logic [SWAP_W-1:0] swap_limit_reg, swap_limit_next;
    logic [CW-1:0]     seg_count_reg, seg_count_next;
    logic [AGE_W-1:0]  load_clock_reg, load_clock_next;
    logic [UW-1:0]     used_reg, used_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     left_reg, left_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [AW-1:0]     wb_addr_reg, wb_addr_next;
    logic              sh_up_reg, sh_up_next;
    logic [CW-1:0]     proc_idx_reg, proc_idx_next;
    logic [HW-1:0]     holes_reg, holes_next;
    logic              fit_found_reg, fit_found_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers
    logic [ID_W-1:0]   rq_id_reg, rq_id_next;
    logic [UW-1:0]     rq_size_reg, rq_size_next;
    logic [SWAP_W-1:0] rq_swaps_reg, rq_swaps_next;
    logic [UW-1:0]     prev_end_reg, prev_end_next;
    logic [UW-1:0]     fit_len_reg, fit_len_next;
    logic [CW-1:0]     fit_idx_reg, fit_idx_next;
    logic [UW-1:0]     fit_begin_reg, fit_begin_next;
    logic [AGE_W-1:0]  old_age_reg, old_age_next;
    logic [AW-1:0]     old_idx_reg, old_idx_next;
    logic [ID_W-1:0]   ev_id_reg, ev_id_next;
    logic [UW-1:0]     ev_size_reg, ev_size_next;
    logic [UW-1:0]     ev_start_reg, ev_start_next;
    logic [SWAP_W-1:0] ev_swaps_reg, ev_swaps_next;
    logic              pend_kind_reg, pend_kind_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic [UW-1:0]     pend_size_reg, pend_size_next;
    logic [UW-1:0]     pend_start_reg, pend_start_next;
    logic [SWAP_W-1:0] pend_swaps_reg, pend_swaps_next;
    logic              pend_rq_reg, pend_rq_next;
    res_item_t         out_reg, out_next;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic [UW-1:0]     rd_start;
    logic [UW-1:0]     rd_size;
    logic [ID_W-1:0]   rd_id;
    logic [SWAP_W-1:0] rd_swaps;
    logic [AGE_W-1:0]  rd_age;

    cfa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign {rd_age, rd_swaps, rd_id, rd_size, rd_start} = ram_rdata;

    // Channel handshakes
    logic out_free;
    logic req_fire;
    assign out_free  = !out_valid_reg || res.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign res.valid          = out_valid_reg;
    assign res.event_kind     = out_reg.event_kind;
    assign res.out_id         = out_reg.out_id;
    assign res.out_size       = out_reg.out_size;
    assign res.out_start      = out_reg.out_start;
    assign res.out_swaps      = out_reg.out_swaps;
    assign res.requeue        = out_reg.requeue;
    assign res.resident_count = out_reg.resident_count;
    assign res.hole_count     = out_reg.hole_count;
    assign res.used_units     = out_reg.used_units;
    assign res.last           = out_reg.last;

    // Gap evaluation shared by every scan step
    logic          issue;
    logic          gap_eval;
    logic [UW-1:0] gap_end;
    logic [UW-1:0] gap_len;
    logic          gap_take;
    logic [AGE_W-1:0] age;

    always_comb
    begin
        issue    = (state_reg == ST_SCAN) && (ptr_reg < seg_count_reg);
        gap_eval = (state_reg == ST_SCAN) && (rd_pend_reg || !issue);
        gap_end  = rd_pend_reg ? rd_start : MEM_TOP;
        gap_len  = gap_end - prev_end_reg;
        age      = load_clock_reg - rd_age;
        gap_take = 1'b0;
        if (gap_len >= rq_size_reg)
        begin
            case (fit_policy_reg)
                POL_BEST:  gap_take = !fit_found_reg || (gap_len <= fit_len_reg);
                POL_WORST: gap_take = !fit_found_reg || (gap_len >= fit_len_reg);
                default:   gap_take = !fit_found_reg;
            endcase
        end
    end

    // Next state and datapath
    logic start_scan;

    always_comb
    begin
        state_next      = state_reg;
        fit_policy_next = fit_policy_reg;
        swap_limit_next = swap_limit_reg;
        seg_count_next  = seg_count_reg;
        load_clock_next = load_clock_reg;
        used_next       = used_reg;
        ptr_next        = ptr_reg;
        left_next       = left_reg;
        rd_pend_next    = 1'b0;
        wb_addr_next    = wb_addr_reg;
        sh_up_next      = sh_up_reg;
        proc_idx_next   = proc_idx_reg;
        holes_next      = holes_reg;
        fit_found_next  = fit_found_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        rq_id_next      = rq_id_reg;
        rq_size_next    = rq_size_reg;
        rq_swaps_next   = rq_swaps_reg;
        prev_end_next   = prev_end_reg;
        fit_len_next    = fit_len_reg;
        fit_idx_next    = fit_idx_reg;
        fit_begin_next  = fit_begin_reg;
        old_age_next    = old_age_reg;
        old_idx_next    = old_idx_reg;
        ev_id_next      = ev_id_reg;
        ev_size_next    = ev_size_reg;
        ev_start_next   = ev_start_reg;
        ev_swaps_next   = ev_swaps_reg;
        pend_kind_next  = pend_kind_reg;
        pend_id_next    = pend_id_reg;
        pend_size_next  = pend_size_reg;
        pend_start_next = pend_start_reg;
        pend_swaps_next = pend_swaps_reg;
        pend_rq_next    = pend_rq_reg;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = wb_addr_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = ptr_reg[AW-1:0];
        start_scan      = 1'b0;

        // Configuration writes
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FIT_POLICY: fit_policy_next = POL_W'(cfg.data);
                REG_SWAP_LIMIT: swap_limit_next = SWAP_W'(cfg.data);
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.req_size != '0)
                    && ({{(32-SIZE_W){1'b0}}, req.req_size} <= 32'(MEM_UNITS)))
                begin
                    rq_id_next    = req.proc_id;
                    rq_size_next  = UW'(req.req_size);
                    rq_swaps_next = req.swap_count;
                    start_scan    = 1'b1;
                end
            end

            ST_SCAN:
            begin
                // Issue the next table read
                if (issue)
                begin
                    ptr_next     = ptr_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
                // Fold in one gap per cycle
                if (gap_eval)
                begin
                    if (gap_len != '0)
                    begin
                        holes_next = holes_reg + 1'b1;
                    end
                    if (gap_take)
                    begin
                        fit_found_next = 1'b1;
                        fit_len_next   = gap_len;
                        fit_idx_next   = proc_idx_reg;
                        fit_begin_next = prev_end_reg;
                    end
                end
                // Entry step: advance past the entry and track the oldest segment
                if (rd_pend_reg)
                begin
                    prev_end_next = rd_start + rd_size;
                    proc_idx_next = proc_idx_reg + 1'b1;
                    if ((proc_idx_reg == '0) || (age > old_age_reg))
                    begin
                        old_age_next  = age;
                        old_idx_next  = proc_idx_reg[AW-1:0];
                        ev_id_next    = rd_id;
                        ev_size_next  = rd_size;
                        ev_start_next = rd_start;
                        ev_swaps_next = rd_swaps;
                    end
                end
                else if (!issue)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    // Deliver the result of the previous change
                    if (pend_valid_reg)
                    begin
                        out_valid_next         = 1'b1;
                        pend_valid_next        = 1'b0;
                        out_next.event_kind     = pend_kind_reg;
                        out_next.out_id         = pend_id_reg;
                        out_next.out_size       = SIZE_W'(pend_size_reg);
                        out_next.out_start      = START_W'(pend_start_reg);
                        out_next.out_swaps      = pend_swaps_reg;
                        out_next.requeue        = pend_rq_reg;
                        out_next.resident_count = CNT_W'(seg_count_reg);
                        out_next.hole_count     = CNT_W'(holes_reg);
                        out_next.used_units     = USED_W'(used_reg);
                        out_next.last           = (pend_kind_reg == EV_PLACE);
                    end

                    if (pend_valid_reg && (pend_kind_reg == EV_PLACE))
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (fit_found_reg && (seg_count_reg < SEG_MAX))
                    begin
                        // Place: open a slot at the chosen gap
                        sh_up_next      = 1'b1;
                        ptr_next        = seg_count_reg - 1'b1;
                        left_next       = seg_count_reg - fit_idx_reg;
                        seg_count_next  = seg_count_reg + 1'b1;
                        load_clock_next = load_clock_reg + 1'b1;
                        used_next       = used_reg + rq_size_reg;
                        pend_valid_next = 1'b1;
                        pend_kind_next  = EV_PLACE;
                        pend_id_next    = rq_id_reg;
                        pend_size_next  = rq_size_reg;
                        pend_start_next = fit_begin_reg;
                        pend_swaps_next = rq_swaps_reg;
                        pend_rq_next    = 1'b0;
                        state_next      = ST_SHIFT;
                    end
                    else
                    begin
                        // Evict the oldest segment and close its slot
                        sh_up_next      = 1'b0;
                        ptr_next        = CW'(old_idx_reg) + 1'b1;
                        left_next       = seg_count_reg - 1'b1 - CW'(old_idx_reg);
                        seg_count_next  = seg_count_reg - 1'b1;
                        used_next       = used_reg - ev_size_reg;
                        pend_valid_next = 1'b1;
                        pend_kind_next  = EV_EVICT;
                        pend_id_next    = ev_id_reg;
                        pend_size_next  = ev_size_reg;
                        pend_start_next = ev_start_reg;
                        pend_swaps_next = (ev_swaps_reg == SWAP_MAX) ? SWAP_MAX
                                                                     : ev_swaps_reg + 1'b1;
                        pend_rq_next    = (ev_swaps_reg < swap_limit_reg);
                        state_next      = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                // Read one entry per cycle, write it one slot over the next cycle
                if (left_reg != '0)
                begin
                    rd_pend_next = 1'b1;
                    left_next    = left_reg - 1'b1;
                    wb_addr_next = sh_up_reg ? AW'(ptr_reg + 1'b1) : AW'(ptr_reg - 1'b1);
                    ptr_next     = sh_up_reg ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
                end
                if (rd_pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if ((left_reg == '0) && !rd_pend_reg)
                begin
                    if (sh_up_reg)
                    begin
                        state_next = ST_INSERT;
                    end
                    else
                    begin
                        start_scan = 1'b1;
                    end
                end
            end

            ST_INSERT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = fit_idx_reg[AW-1:0];
                ram_wdata  = {load_clock_reg - 1'b1, rq_swaps_reg, rq_id_reg,
                              rq_size_reg, fit_begin_reg};
                start_scan = 1'b1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Start a new scan and clear the scan accumulators
        if (start_scan)
        begin
            state_next     = ST_SCAN;
            ptr_next       = '0;
            proc_idx_next  = '0;
            prev_end_next  = '0;
            holes_next     = '0;
            fit_found_next = 1'b0;
            rd_pend_next   = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fit_policy_reg <= POL_FIRST;
            swap_limit_reg <= 4'd3;
            seg_count_reg  <= '0;
            load_clock_reg <= '0;
            used_reg       <= '0;
            ptr_reg        <= '0;
            left_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            sh_up_reg      <= 1'b0;
            proc_idx_reg   <= '0;
            holes_reg      <= '0;
            fit_found_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fit_policy_reg <= fit_policy_next;
            swap_limit_reg <= swap_limit_next;
            seg_count_reg  <= seg_count_next;
            load_clock_reg <= load_clock_next;
            used_reg       <= used_next;
            ptr_reg        <= ptr_next;
            left_reg       <= left_next;
            rd_pend_reg    <= rd_pend_next;
            sh_up_reg      <= sh_up_next;
            proc_idx_reg   <= proc_idx_next;
            holes_reg      <= holes_next;
            fit_found_reg  <= fit_found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        wb_addr_reg    <= wb_addr_next;
        rq_id_reg      <= rq_id_next;
        rq_size_reg    <= rq_size_next;
        rq_swaps_reg   <= rq_swaps_next;
        prev_end_reg   <= prev_end_next;
        fit_len_reg    <= fit_len_next;
        fit_idx_reg    <= fit_idx_next;
        fit_begin_reg  <= fit_begin_next;
        old_age_reg    <= old_age_next;
        old_idx_reg    <= old_idx_next;
        ev_id_reg      <= ev_id_next;
        ev_size_reg    <= ev_size_next;
        ev_start_reg   <= ev_start_next;
        ev_swaps_reg   <= ev_swaps_next;
        pend_kind_reg  <= pend_kind_next;
        pend_id_reg    <= pend_id_next;
        pend_size_reg  <= pend_size_next;
        pend_start_reg <= pend_start_next;
        pend_swaps_reg <= pend_swaps_next;
        pend_rq_reg    <= pend_rq_next;
        out_reg        <= out_next;
    end

endmodule

`default_nettype wire
